// ===== rtl/core/ps2me_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the PS/2 mouse packet event decoder.
// No dependencies.
package ps2me_pkg;

    // Packet byte phase
    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_X    = 2'd1;
    localparam logic [1:0] PH_Y    = 2'd2;

    // Event kinds
    localparam logic [2:0] KIND_MOVE     = 3'd0;
    localparam logic [2:0] KIND_LEFT_DN  = 3'd1;
    localparam logic [2:0] KIND_LEFT_UP  = 3'd2;
    localparam logic [2:0] KIND_RIGHT_DN = 3'd3;
    localparam logic [2:0] KIND_RIGHT_UP = 3'd4;
    localparam logic [2:0] KIND_MID_DN   = 3'd5;
    localparam logic [2:0] KIND_MID_UP   = 3'd6;

    // Header bits
    localparam int HDR_SYNC   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    localparam int NUM_EVENTS = 4;  // move, left, right, middle

    typedef logic [NUM_EVENTS-1:0] ev_mask_t;

endpackage

// ===== rtl/core/ps2_mouse_packet_events.sv =====
`timescale 1ns / 1ps
// PS/2 mouse three-byte packet decoder: bytes in, move and button events out.
// Depends on ps2me_pkg.
//
//  channel | dir | tdata                                   | tuser          | tlast
//  s_      | in  | [7:0] data_byte, [15:8] free_slots      | -              | -
//  m_      | out | [8:0] delta_x, [18:9] delta_y, 0 pad    | [2:0] event_kind | last_event
//
// Header and X bytes are accepted back to back.
// A Y byte queues 0 to 4 events in a pending register; they leave one per
// cycle unless stalled; the next byte is accepted in the cycle the final event is taken.
// Back pressure on m_ holds the pending events and s_tready low.
// aresetn (synchronous) clears the phase, held buttons and pending events.
module ps2_mouse_packet_events
    import ps2me_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] free_slots
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [8:0] delta_x, [18:9] delta_y, [23:19] zero
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    output logic        m_tlast
);

    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        header_reg, header_next;
    logic [7:0]        xbyte_reg, xbyte_next;
    logic [2:0]        buttons_reg, buttons_next;
    ev_mask_t          pend_reg, pend_next;
    logic [2:0]        btn_now_reg, btn_now_next;
    logic signed [8:0] dx_reg, dx_next;
    logic signed [9:0] dy_reg, dy_next;

    logic [7:0]        in_byte;
    logic [7:0]        in_slots;
    logic              s_accept;
    logic              m_accept;
    logic              drain_last;
    logic signed [8:0] dx_calc;
    logic signed [9:0] y_val;
    logic signed [9:0] dy_calc;
    ev_mask_t          ev_raw;
    ev_mask_t          ev_kept;
    logic [2:0]        ev_cnt;
    ev_mask_t          pend_low;
    ev_mask_t          pend_drained;

    assign in_byte  = s_tdata[7:0];
    assign in_slots = s_tdata[15:8];

    // ---------------------------------------------------------------
    // Output side: lowest pending event is presented
    // ---------------------------------------------------------------
    assign pend_low     = pend_reg & (~pend_reg + ev_mask_t'(1));
    assign m_tvalid     = |pend_reg;
    assign m_tlast      = $onehot(pend_reg);
    assign m_accept     = m_tvalid && m_tready;
    assign drain_last   = m_accept && m_tlast;
    assign pend_drained = m_accept ? (pend_reg & ~pend_low) : pend_reg;

    assign s_tready = (pend_reg == '0) || drain_last;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        m_tuser = KIND_MOVE;
        m_tdata = '0;
        unique case (1'b1)
            pend_low[0]: begin
                m_tuser = KIND_MOVE;
                m_tdata = {5'd0, dy_reg, dx_reg};
            end
            pend_low[1]: m_tuser = btn_now_reg[0] ? KIND_LEFT_DN  : KIND_LEFT_UP;
            pend_low[2]: m_tuser = btn_now_reg[1] ? KIND_RIGHT_DN : KIND_RIGHT_UP;
            pend_low[3]: m_tuser = btn_now_reg[2] ? KIND_MID_DN   : KIND_MID_UP;
            default:     m_tuser = KIND_MOVE;
        endcase
    end

    // ---------------------------------------------------------------
    // Input side: one pass over the accepted byte
    // ---------------------------------------------------------------
    always_comb begin
        if (header_reg[HDR_XOVF]) begin
            dx_calc = '0;
        end else begin
            dx_calc = {header_reg[HDR_XSIGN], xbyte_reg};
        end
        y_val = {{2{header_reg[HDR_YSIGN]}}, in_byte};
        if (header_reg[HDR_YOVF]) begin
            dy_calc = '0;
        end else begin
            dy_calc = -y_val;
        end
    end

    // Keep only as many events as the consumer has room for
    always_comb begin
        ev_raw  = {header_reg[2:0] ^ buttons_reg, (dx_calc != '0) || (dy_calc != '0)};
        ev_kept = '0;
        ev_cnt  = '0;
        for (int i = 0; i < NUM_EVENTS; i++) begin
            if (ev_raw[i] && ({5'd0, ev_cnt} < in_slots)) begin
                ev_kept[i] = 1'b1;
                ev_cnt     = ev_cnt + 3'd1;
            end
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        header_next  = header_reg;
        xbyte_next   = xbyte_reg;
        buttons_next = buttons_reg;
        pend_next    = pend_drained;
        btn_now_next = btn_now_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        if (s_accept) begin
            unique case (phase_reg)
                PH_X: begin
                    xbyte_next = in_byte;
                    phase_next = PH_Y;
                end
                PH_Y: begin
                    phase_next = PH_HEAD;
                    if (in_slots != '0) begin
                        buttons_next = header_reg[2:0];
                        btn_now_next = header_reg[2:0];
                        pend_next    = ev_kept;
                        dx_next      = dx_calc;
                        dy_next      = dy_calc;
                    end
                end
                default: begin
                    // header byte; an unused phase code is treated the same
                    header_next = in_byte;
                    phase_next  = in_byte[HDR_SYNC] ? PH_X : PH_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEAD;
            header_reg  <= '0;
            xbyte_reg   <= '0;
            buttons_reg <= '0;
            pend_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            header_reg  <= header_next;
            xbyte_reg   <= xbyte_next;
            buttons_reg <= buttons_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        btn_now_reg <= btn_now_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
    end

`ifndef SYNTH
    // Header and X bytes never leave an event behind
    a_no_event_after_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg == PH_X) |=> !m_tvalid)
        else $error("event pending after X byte");

    // A packet with no free slots is dropped whole
    a_zero_slots_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg == PH_Y && in_slots == 8'd0)
            |=> ($stable(buttons_reg) && !m_tvalid))
        else $error("packet with no free slots changed state or emitted");

    // Button events carry no movement
    a_button_zero_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_MOVE) |-> (m_tdata == 24'd0))
        else $error("button event with nonzero delta");
`endif

endmodule

// ===== test/ps2_mouse_packet_events_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ps2_mouse_packet_events: streams mouse bytes in,
// predicts the move and button events and checks each one as it leaves.
// Depends on ps2me_pkg and the ps2_mouse_packet_events RTL.
module testbench
    import ps2me_pkg::*;
();

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 180;

    typedef struct packed {
        logic [2:0] kind;
        logic [8:0] dx;
        logic [9:0] dy;
        logic       last;
    } mouse_event_t;

    // Tracks the packet decoder state and the events still owed by the block.
    class mouse_event_board;
        logic [1:0]   phase;
        logic [7:0]   header;
        logic [7:0]   x_move;
        logic [2:0]   held;
        mouse_event_t pending_events[$];
        int           mismatches;

        function new();
            phase      = PH_HEAD;
            header     = '0;
            x_move     = '0;
            held       = '0;
            mismatches = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic [7:0] slots);
            int           dx;
            int           dy;
            mouse_event_t ev;
            mouse_event_t burst[$];
            if (phase == PH_X) begin
                x_move = b;
                phase  = PH_Y;
                return;
            end
            if (phase != PH_Y) begin
                header = b;
                phase  = b[HDR_SYNC] ? PH_X : PH_HEAD;
                return;
            end
            phase = PH_HEAD;

            dx = int'(x_move);
            if (header[HDR_XOVF])
                dx = 0;
            else if (header[HDR_XSIGN])
                dx -= 256;
            dy = -int'(b);
            if (header[HDR_YOVF])
                dy = 0;
            else if (header[HDR_YSIGN])
                dy += 256;

            // no room downstream: packet dropped, buttons keep their old state
            if (slots == 0)
                return;

            if (dx != 0 || dy != 0) begin
                ev.kind = KIND_MOVE;
                ev.dx   = dx[8:0];
                ev.dy   = dy[9:0];
                ev.last = 1'b0;
                burst.push_back(ev);
            end
            for (int i = 0; i < 3; i++) begin
                if (held[i] != header[i] && burst.size() < slots) begin
                    case (i)
                        0:       ev.kind = header[i] ? KIND_LEFT_DN  : KIND_LEFT_UP;
                        1:       ev.kind = header[i] ? KIND_RIGHT_DN : KIND_RIGHT_UP;
                        default: ev.kind = header[i] ? KIND_MID_DN   : KIND_MID_UP;
                    endcase
                    ev.dx   = '0;
                    ev.dy   = '0;
                    ev.last = 1'b0;
                    burst.push_back(ev);
                end
            end
            // events cut by the slot count are lost, the button state is not
            held = header[2:0];
            if (burst.size() > 0)
                burst[burst.size()-1].last = 1'b1;
            foreach (burst[k])
                pending_events.push_back(burst[k]);
        endfunction

        function void check_event(mouse_event_t got);
            mouse_event_t want;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: kind %0d dx %0d dy %0d last %0d",
                             got.kind, $signed(got.dx), $signed(got.dy), got.last);
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind || got.dx !== want.dx ||
                got.dy !== want.dy || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("event mismatch: expected kind %0d dx %0d dy %0d last %0d, %s",
                             want.kind, $signed(want.dx), $signed(want.dy), want.last,
                             $sformatf("got kind %0d dx %0d dy %0d last %0d", got.kind,
                                       $signed(got.dx), $signed(got.dy), got.last));
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    logic             calm = 1'b0;  // no idling on either side while set
    int               idle_cycles = 0;
    mouse_event_board board;

    always #1 aclk = ~aclk;

    ps2_mouse_packet_events dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic int pause();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [7:0] slots);
        int gap;
        gap = pause();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {slots, b};
        do @(posedge aclk); while (!s_tready);
        board.note_byte(b, slots);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] x,
                               input logic [7:0] y, input logic [7:0] slots);
        send_byte(hdr, 8'($urandom_range(0, 255)));
        send_byte(x, 8'($urandom_range(0, 255)));
        send_byte(y, slots);
    endtask

    // event sink with random stalls
    initial begin
        int           stall;
        mouse_event_t got;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = pause();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.kind = m_tuser;
            got.dx   = m_tdata[8:0];
            got.dy   = m_tdata[18:9];
            got.last = m_tlast;
            board.check_event(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         sent;
        logic [7:0] hdr;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] slots;
        board = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // headers without the sync bit are dropped
        send_byte(8'h00, 8'h00);
        send_byte(8'hF7, 8'hFF);
        send_packet(8'h08, 8'h00, 8'h00, 8'd255);  // nothing to report
        send_packet(8'h0F, 8'h01, 8'h01, 8'd255);  // move plus all buttons down
        send_packet(8'h38, 8'h00, 8'h00, 8'd128);  // dx -256, dy 256, all buttons up
        send_packet(8'hCF, 8'h55, 8'hAA, 8'd255);  // both axes overflow
        send_packet(8'h08, 8'h05, 8'h05, 8'd0);    // no slots: whole packet dropped
        send_packet(8'h08, 8'hFF, 8'hFF, 8'd2);    // dx 255, dy -255, truncated
        send_packet(8'h1D, 8'hFF, 8'h01, 8'd1);    // dx -1, single slot

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 29) == 0)
                calm = ~calm;
            if ($urandom_range(0, 9) == 0) begin
                // stray byte, may break the packet framing
                send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                sent += 1;
            end else begin
                hdr = 8'($urandom_range(0, 255));
                hdr[HDR_SYNC] = 1'b1;
                if ($urandom_range(0, 2) != 0) begin
                    hdr[HDR_XOVF] = 1'b0;
                    hdr[HDR_YOVF] = 1'b0;
                end
                x = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                y = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                case ($urandom_range(0, 7))
                    0:       slots = 8'd0;
                    1, 2:    slots = 8'($urandom_range(1, 4));
                    default: slots = 8'($urandom_range(0, 255));
                endcase
                send_packet(hdr, x, y, slots);
                sent += 3;
            end
        end
        s_tvalid <= 1'b0;

        while (board.pending_events.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
